/* sv/deq_pkg.sv */
// Package with the sizes, codes, types and ring helpers of the double-ended queue.
package deq_pkg;

	localparam int DEPTH      = 16;
	localparam int DATA_WIDTH = 32;
	localparam int IDX_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W      = $clog2(DEPTH + 1);
	localparam int SUM_W      = CNT_W + 1;

	localparam int OP_W     = 3;
	localparam int VALUE_W  = 32;
	localparam int COUNT_W  = 5;
	localparam int STATUS_W = 2;

	typedef logic [OP_W-1:0]       op_t;
	typedef logic [STATUS_W-1:0]   status_t;
	typedef logic [DATA_WIDTH-1:0] data_t;
	typedef logic [IDX_W-1:0]      idx_t;
	typedef logic [CNT_W-1:0]      cnt_t;

	localparam op_t OP_PUSH_REAR  = 3'd0;
	localparam op_t OP_PUSH_FRONT = 3'd1;
	localparam op_t OP_POP_FRONT  = 3'd2;
	localparam op_t OP_POP_REAR   = 3'd3;
	localparam op_t OP_QUERY      = 3'd4;

	localparam status_t ST_OK         = 2'd0;
	localparam status_t ST_POP_EMPTY  = 2'd1;
	localparam status_t ST_PUSH_FULL  = 2'd2;

	localparam cnt_t CNT_FULL = CNT_W'(DEPTH);

	typedef struct packed {
		logic exec;
		logic read;
		logic load;
	} deq_cmd_t;

	function automatic idx_t ring_wrap(input logic [SUM_W-1:0] sum);
		logic [SUM_W-1:0] wrapped;
		wrapped = (sum >= SUM_W'(DEPTH)) ? sum - SUM_W'(DEPTH) : sum;
		return wrapped[IDX_W-1:0];
	endfunction

endpackage

/* sv/deq_if.sv */
// Valid/ready channel interfaces for the request and the response words of the queue.
interface deq_req_if;
	logic                        valid;
	logic                        ready;
	deq_pkg::op_t                operation;
	logic signed [deq_pkg::VALUE_W-1:0] value;

	modport source (output valid, output operation, output value, input ready);
	modport sink (input valid, input operation, input value, output ready);
endinterface

interface deq_rsp_if;
	logic                               valid;
	logic                               ready;
	logic signed [deq_pkg::VALUE_W-1:0] front_value;
	logic signed [deq_pkg::VALUE_W-1:0] rear_value;
	logic [deq_pkg::COUNT_W-1:0]        element_count;
	logic                               is_empty;
	deq_pkg::status_t                   status;

	modport source (output valid, output front_value, output rear_value,
		output element_count, output is_empty, output status, input ready);
	modport sink (input valid, input front_value, input rear_value,
		input element_count, input is_empty, input status, output ready);
endinterface

/* sv/deq_ctrl.sv */
// Controller state machine that sequences accept, store read and response load.
module deq_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output deq_pkg::deq_cmd_t cmd
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_READ = 2'd1;
	localparam logic [1:0] ST_LOAD = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_next;
	logic       out_valid_q;
	logic       accept;
	logic       out_free;

	assign req_ready = (state_q == ST_IDLE);
	assign accept    = req_valid && req_ready;
	assign out_free  = !out_valid_q || rsp_ready;
	assign rsp_valid = out_valid_q;

	assign cmd.exec = accept;
	assign cmd.read = (state_q == ST_READ);
	assign cmd.load = (state_q == ST_LOAD) && out_free;

	always_comb begin
		state_next = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_next = ST_READ;
				end
			end
			ST_READ: begin
				state_next = ST_LOAD;
			end
			ST_LOAD: begin
				if (out_free) begin
					state_next = ST_IDLE;
				end
			end
			default: begin
				state_next = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_next;
			if (cmd.load) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	a_accept_to_read: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == ST_READ))
		else $error("accepted word did not start a store read");

	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !rsp_ready) |=> out_valid_q)
		else $error("pending response word was dropped");

endmodule

/* sv/deq_dpath.sv */
// Datapath with the ring store, head index, element count and response registers.
module deq_dpath (
	input  logic                               clk,
	input  logic                               arst_n,
	input  deq_pkg::deq_cmd_t                  cmd,
	input  deq_pkg::op_t                       operation,
	input  logic signed [deq_pkg::VALUE_W-1:0] value,
	output logic signed [deq_pkg::VALUE_W-1:0] front_value,
	output logic signed [deq_pkg::VALUE_W-1:0] rear_value,
	output logic [deq_pkg::COUNT_W-1:0]        element_count,
	output logic                               is_empty,
	output deq_pkg::status_t                   status
);

	deq_pkg::data_t   mem [deq_pkg::DEPTH];
	deq_pkg::idx_t    head_q;
	deq_pkg::cnt_t    count_q;
	deq_pkg::status_t status_q;
	deq_pkg::data_t   rd_front_q;
	deq_pkg::data_t   rd_rear_q;

	deq_pkg::data_t   word;
	deq_pkg::idx_t    head_prev;
	deq_pkg::idx_t    head_next;
	deq_pkg::idx_t    tail_addr;
	deq_pkg::idx_t    rear_addr;
	deq_pkg::idx_t    wr_addr;
	logic             wr_en;
	logic             is_full;
	logic             is_zero;
	deq_pkg::idx_t    head_d;
	deq_pkg::cnt_t    count_d;
	deq_pkg::status_t status_d;

	assign word      = deq_pkg::DATA_WIDTH'(unsigned'(value));
	assign is_full   = (count_q >= deq_pkg::CNT_FULL);
	assign is_zero   = (count_q == '0);
	assign head_prev = (head_q == '0) ? deq_pkg::IDX_W'(deq_pkg::DEPTH - 1) : head_q - 1'b1;
	assign head_next = (head_q == deq_pkg::IDX_W'(deq_pkg::DEPTH - 1)) ? '0 : head_q + 1'b1;
	assign tail_addr = deq_pkg::ring_wrap(deq_pkg::SUM_W'(head_q) + deq_pkg::SUM_W'(count_q));
	assign rear_addr = deq_pkg::ring_wrap(deq_pkg::SUM_W'(head_q)
		+ deq_pkg::SUM_W'(count_q - 1'b1));

	always_comb begin
		head_d   = head_q;
		count_d  = count_q;
		status_d = deq_pkg::ST_OK;
		wr_en    = 1'b0;
		wr_addr  = tail_addr;
		case (operation)
			deq_pkg::OP_PUSH_REAR: begin
				if (is_full) begin
					status_d = deq_pkg::ST_PUSH_FULL;
				end else begin
					wr_en   = 1'b1;
					count_d = count_q + 1'b1;
				end
			end
			deq_pkg::OP_PUSH_FRONT: begin
				wr_addr = head_prev;
				if (is_full) begin
					status_d = deq_pkg::ST_PUSH_FULL;
				end else begin
					wr_en   = 1'b1;
					head_d  = head_prev;
					count_d = count_q + 1'b1;
				end
			end
			deq_pkg::OP_POP_FRONT: begin
				if (is_zero) begin
					status_d = deq_pkg::ST_POP_EMPTY;
				end else begin
					head_d  = head_next;
					count_d = count_q - 1'b1;
				end
			end
			deq_pkg::OP_POP_REAR: begin
				if (is_zero) begin
					status_d = deq_pkg::ST_POP_EMPTY;
				end else begin
					count_d = count_q - 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.exec && wr_en) begin
			mem[wr_addr] <= word;
		end
		if (cmd.read) begin
			rd_front_q <= mem[head_q];
			rd_rear_q  <= mem[rear_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q   <= '0;
			count_q  <= '0;
			status_q <= deq_pkg::ST_OK;
		end else if (cmd.exec) begin
			head_q   <= head_d;
			count_q  <= count_d;
			status_q <= status_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			front_value   <= is_zero ? '0 : deq_pkg::VALUE_W'(rd_front_q);
			rear_value    <= is_zero ? '0 : deq_pkg::VALUE_W'(rd_rear_q);
			element_count <= deq_pkg::COUNT_W'(count_q);
			is_empty      <= is_zero;
			status        <= status_q;
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= deq_pkg::CNT_FULL)
		else $error("element count exceeds the ring depth");

	a_head_bound: assert property (@(posedge clk) disable iff (!arst_n)
		head_q <= deq_pkg::IDX_W'(deq_pkg::DEPTH - 1))
		else $error("head index outside the ring");

	a_full_push_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.exec && is_full && (operation == deq_pkg::OP_PUSH_REAR
			|| operation == deq_pkg::OP_PUSH_FRONT))
		|=> ($stable(count_q) && $stable(head_q) && status_q == deq_pkg::ST_PUSH_FULL))
		else $error("push on a full queue changed the state");

endmodule

/* sv/double_ended_queue_top.sv */
// Top level of the bounded double-ended queue: controller, datapath and channel wiring.
//
//   channel  dir  contents
//   req      in   operation, value
//   rsp      out  front_value, rear_value, element_count, is_empty, status
//
// Each request word passes through accept and update, ring store read and response load, in that order.
// The ring store is read at the front and the rear address after the update.
// The response register lets the next request be accepted while a response word waits.
// A stalled response holds the controller in its load state until the register frees.
// Reset clears the head index, element count and handshake state; the store is not cleared.
module double_ended_queue_top (
	input logic         clk,
	input logic         arst_n,
	deq_req_if.sink     req,
	deq_rsp_if.source   rsp
);

	deq_pkg::deq_cmd_t cmd;

	deq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.cmd       (cmd)
	);

	deq_dpath u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.operation     (req.operation),
		.value         (req.value),
		.front_value   (rsp.front_value),
		.rear_value    (rsp.rear_value),
		.element_count (rsp.element_count),
		.is_empty      (rsp.is_empty),
		.status        (rsp.status)
	);

endmodule

/* tb/sv/tb.sv */
// Self-checking testbench for the bounded double-ended queue with random idling on both channels.
module tb;

	localparam int HOLD_CYCLES   = 100;
	localparam int RANDOM_WORDS  = 450;
	localparam int HOLD_AT       = 150;
	localparam int STEADY_UNTIL  = 190;
	localparam int CALM_FROM     = 390;

	typedef struct packed {
		logic signed [deq_pkg::VALUE_W-1:0] front_value;
		logic signed [deq_pkg::VALUE_W-1:0] rear_value;
		logic [deq_pkg::COUNT_W-1:0]        element_count;
		logic                               is_empty;
		deq_pkg::status_t                   status;
	} queue_view_t;

	typedef struct packed {
		deq_pkg::op_t   op;
		deq_pkg::data_t value;
		logic           drain;
		logic           hold;
		logic           steady;
		logic           calm;
	} request_word_t;

	logic clk;
	logic arst_n;

	deq_req_if req ();
	deq_rsp_if rsp ();

	double_ended_queue_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	request_word_t pending[$];
	request_word_t launch;
	queue_view_t   awaited_views[$];
	queue_view_t   seen_view;
	queue_view_t   want_view;

	deq_pkg::data_t deq_ring[deq_pkg::DEPTH];
	deq_pkg::idx_t  deq_head;
	deq_pkg::cnt_t  deq_fill;

	int   fail_count;
	int   pending_total;
	int   words_sent;
	int   send_gap;
	int   stall_left;
	int   hold_left;
	int   holds_asked;
	int   holds_served;
	logic calm_phase;
	logic drained;

	function automatic queue_view_t apply_deq_op(input deq_pkg::op_t op,
		input deq_pkg::data_t word);
		queue_view_t view;
		view = '0;
		view.status = deq_pkg::ST_OK;
		case (op)
			deq_pkg::OP_PUSH_REAR: begin
				if (deq_fill == deq_pkg::CNT_FULL) begin
					view.status = deq_pkg::ST_PUSH_FULL;
				end else begin
					deq_ring[deq_pkg::idx_t'((int'(deq_head) + int'(deq_fill))
						% deq_pkg::DEPTH)] = word;
					deq_fill = deq_fill + 1'b1;
				end
			end
			deq_pkg::OP_PUSH_FRONT: begin
				if (deq_fill == deq_pkg::CNT_FULL) begin
					view.status = deq_pkg::ST_PUSH_FULL;
				end else begin
					deq_head = deq_pkg::idx_t'((int'(deq_head) + deq_pkg::DEPTH - 1)
						% deq_pkg::DEPTH);
					deq_ring[deq_head] = word;
					deq_fill = deq_fill + 1'b1;
				end
			end
			deq_pkg::OP_POP_FRONT: begin
				if (deq_fill == '0) begin
					view.status = deq_pkg::ST_POP_EMPTY;
				end else begin
					deq_head = deq_pkg::idx_t'((int'(deq_head) + 1) % deq_pkg::DEPTH);
					deq_fill = deq_fill - 1'b1;
				end
			end
			deq_pkg::OP_POP_REAR: begin
				if (deq_fill == '0) begin
					view.status = deq_pkg::ST_POP_EMPTY;
				end else begin
					deq_fill = deq_fill - 1'b1;
				end
			end
			default: begin
			end
		endcase
		if (deq_fill != '0) begin
			view.front_value = deq_ring[deq_head];
			view.rear_value  = deq_ring[deq_pkg::idx_t'((int'(deq_head) + int'(deq_fill) - 1)
				% deq_pkg::DEPTH)];
		end
		view.element_count = deq_pkg::COUNT_W'(deq_fill);
		view.is_empty      = (deq_fill == '0);
		return view;
	endfunction

	function automatic deq_pkg::data_t pick_value();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			2: return {1'b1, {(deq_pkg::DATA_WIDTH-1){1'b0}}};
			3: return {1'b0, {(deq_pkg::DATA_WIDTH-1){1'b1}}};
			default: return deq_pkg::data_t'($urandom);
		endcase
	endfunction

	function automatic deq_pkg::op_t pick_op(input int push_pct);
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 6)
			return deq_pkg::OP_QUERY | deq_pkg::op_t'($urandom_range(0, 3));
		if (roll < 6 + (push_pct * 94) / 100)
			return $urandom_range(0, 1) ? deq_pkg::OP_PUSH_FRONT : deq_pkg::OP_PUSH_REAR;
		return $urandom_range(0, 1) ? deq_pkg::OP_POP_FRONT : deq_pkg::OP_POP_REAR;
	endfunction

	task automatic add_word(input deq_pkg::op_t op, input deq_pkg::data_t value,
		input logic drain, input logic hold, input logic steady, input logic calm);
		request_word_t w;
		w.op     = op;
		w.value  = value;
		w.drain  = drain;
		w.hold   = hold;
		w.steady = steady | calm;
		w.calm   = calm;
		pending.push_back(w);
	endtask

	initial clk = 1'b0;
	always #5 clk = ~clk;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req.valid     <= 1'b0;
			req.operation <= deq_pkg::OP_QUERY;
			req.value     <= '0;
			send_gap      <= 0;
			words_sent    <= 0;
			holds_asked   <= 0;
			calm_phase    <= 1'b0;
		end else if (!req.valid || req.ready) begin
			if (send_gap != 0) begin
				send_gap  <= send_gap - 1;
				req.valid <= 1'b0;
			end else if (pending.size() == 0 || (pending[0].drain && (req.valid || !drained))) begin
				req.valid <= 1'b0;
			end else if (!pending[0].steady && !calm_phase && $urandom_range(0, 7) == 0) begin
				send_gap  <= $urandom_range(0, 18);
				req.valid <= 1'b0;
			end else begin
				launch = pending.pop_front();
				req.valid     <= 1'b1;
				req.operation <= launch.op;
				req.value     <= launch.value;
				words_sent    <= words_sent + 1;
				if (launch.hold)
					holds_asked <= holds_asked + 1;
				if (launch.calm)
					calm_phase <= 1'b1;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp.ready    <= 1'b0;
			stall_left   <= 0;
			hold_left    <= 0;
			holds_served <= 0;
		end else if (holds_served != holds_asked) begin
			holds_served <= holds_asked;
			hold_left    <= HOLD_CYCLES - 1;
			rsp.ready    <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			rsp.ready <= 1'b0;
		end else if (calm_phase) begin
			rsp.ready <= 1'b1;
		end else if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			rsp.ready  <= 1'b0;
		end else if ($urandom_range(0, 7) == 0) begin
			stall_left <= $urandom_range(0, 18);
			rsp.ready  <= 1'b0;
		end else begin
			rsp.ready <= 1'b1;
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deq_head = '0;
			deq_fill = '0;
			drained <= 1'b1;
		end else begin
			if (rsp.valid && rsp.ready) begin
				seen_view.front_value   = rsp.front_value;
				seen_view.rear_value    = rsp.rear_value;
				seen_view.element_count = rsp.element_count;
				seen_view.is_empty      = rsp.is_empty;
				seen_view.status        = rsp.status;
				if (awaited_views.size() == 0) begin
					$error("response word arrived with no request outstanding");
					fail_count++;
				end else begin
					want_view = awaited_views.pop_front();
					if (seen_view.front_value !== want_view.front_value) begin
						$error("front_value expected %0d, got %0d",
							want_view.front_value, seen_view.front_value);
						fail_count++;
					end
					if (seen_view.rear_value !== want_view.rear_value) begin
						$error("rear_value expected %0d, got %0d",
							want_view.rear_value, seen_view.rear_value);
						fail_count++;
					end
					if (seen_view.element_count !== want_view.element_count) begin
						$error("element_count expected %0d, got %0d",
							want_view.element_count, seen_view.element_count);
						fail_count++;
					end
					if (seen_view.is_empty !== want_view.is_empty) begin
						$error("is_empty expected %0d, got %0d",
							want_view.is_empty, seen_view.is_empty);
						fail_count++;
					end
					if (seen_view.status !== want_view.status) begin
						$error("status expected %0d, got %0d",
							want_view.status, seen_view.status);
						fail_count++;
					end
				end
			end
			if (req.valid && req.ready)
				awaited_views.push_back(apply_deq_op(req.operation, req.value));
			drained <= (awaited_views.size() == 0);
		end
	end

	initial begin
		int n;
		int seg_len;
		int push_pct;
		arst_n = 1'b0;
		fail_count = 0;

		add_word(deq_pkg::OP_POP_FRONT, pick_value(), 1'b0, 1'b0, 1'b0, 1'b0);
		add_word(deq_pkg::OP_POP_REAR, pick_value(), 1'b0, 1'b0, 1'b0, 1'b0);
		add_word(deq_pkg::OP_QUERY, '1, 1'b0, 1'b0, 1'b0, 1'b0);
		add_word(deq_pkg::OP_QUERY | deq_pkg::op_t'(1), '1, 1'b0, 1'b0, 1'b0, 1'b0);
		add_word(deq_pkg::OP_QUERY | deq_pkg::op_t'(2), '0, 1'b0, 1'b0, 1'b0, 1'b0);
		add_word(deq_pkg::OP_QUERY | deq_pkg::op_t'(3), '1, 1'b0, 1'b0, 1'b0, 1'b0);
		add_word(deq_pkg::OP_PUSH_REAR, deq_pkg::data_t'($urandom),
			1'b0, 1'b0, 1'b0, 1'b0);
		add_word(deq_pkg::OP_POP_FRONT, '0, 1'b0, 1'b0, 1'b0, 1'b0);
		add_word(deq_pkg::OP_PUSH_REAR, {1'b0, {(deq_pkg::DATA_WIDTH-1){1'b1}}},
			1'b0, 1'b0, 1'b0, 1'b0);
		add_word(deq_pkg::OP_PUSH_FRONT, {1'b1, {(deq_pkg::DATA_WIDTH-1){1'b0}}},
			1'b0, 1'b0, 1'b0, 1'b0);
		for (int i = 0; i < deq_pkg::DEPTH - 2; i++)
			add_word(i[0] ? deq_pkg::OP_PUSH_FRONT : deq_pkg::OP_PUSH_REAR, pick_value(),
				1'b0, 1'b0, 1'b0, 1'b0);
		add_word(deq_pkg::OP_PUSH_REAR, '1, 1'b0, 1'b0, 1'b0, 1'b0);
		add_word(deq_pkg::OP_PUSH_FRONT, '0, 1'b0, 1'b0, 1'b0, 1'b0);

		n = 0;
		while (n < RANDOM_WORDS) begin
			seg_len = $urandom_range(8, 40);
			case ($urandom_range(0, 2))
				0: push_pct = 80;
				1: push_pct = 20;
				default: push_pct = 50;
			endcase
			for (int k = 0; k < seg_len && n < RANDOM_WORDS; k++) begin
				add_word(pick_op(push_pct), pick_value(),
					(n == 100 || n == 300), (n == HOLD_AT),
					(n >= HOLD_AT && n < STEADY_UNTIL), (n >= CALM_FROM));
				n++;
			end
		end
		pending_total = pending.size();

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		do @(posedge clk);
		while (!(words_sent == pending_total && !req.valid && drained));
		repeat (12) @(posedge clk);

		if (fail_count == 0 && awaited_views.size() == 0) begin
			$display("double_ended_queue_top verification clean");
		end else begin
			$display("double_ended_queue_top verification failed");
		end
		$finish;
	end

	initial begin
		#3000000;
		$display("double_ended_queue_top verification failed");
		$finish;
	end

endmodule
